// File: rtl/core/stereo_feedback_delay_line_core_defines.svh
// Assertion macros for the stereo feedback delay line core.
// Used by the checker file; needs clk and rst in the scope of use.
`ifndef STEREO_FEEDBACK_DELAY_LINE_CORE_DEFINES_SVH
`define STEREO_FEEDBACK_DELAY_LINE_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define SFDL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sfdl assertion failed");

// Next-cycle implication, checked outside reset
`define SFDL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sfdl assertion failed");

`endif

// File: rtl/core/sfdl_pkg.sv
// Shared constants and types of the stereo feedback delay line.
// No dependencies.
`timescale 1ns / 1ps

package sfdl_pkg;

  localparam int CFG_DATA_W  = 18;
  localparam int CFG_INDEX_W = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_ACTIVE_LENGTH,
    CFG_DELAY_FRACTION,
    CFG_WET_LEVEL,
    CFG_FEEDBACK_GAIN
  } cfg_index_t;

  localparam logic [17:0] ACTIVE_LEN_RESET = 18'd96000;
  localparam logic [16:0] LEVEL_MAX        = 17'd65536;
  localparam logic [15:0] FB_MAX           = 16'd62259;
  // Q0.32 smoothing coefficients
  localparam logic [15:0] COEF_DELAY       = 16'd42950;
  localparam logic [18:0] COEF_SLOW        = 19'd429497;

  // Operation of one channel datapath in a given cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_RD,
    OP_OLD,
    OP_WR,
    OP_CLR,
    OP_CAP1,
    OP_M1,
    OP_M2,
    OP_WET,
    OP_MX1,
    OP_MX2,
    OP_OUT
  } chan_op_t;

  typedef struct packed {
    chan_op_t op;
  } chan_ctrl_t;

endpackage

// File: rtl/core/sfdl_in_if.sv
// Input stream interface: one stereo sample pair per beat.
// Standalone, parameterised on sample width.
`timescale 1ns / 1ps

interface sfdl_in_if #(parameter int SAMPLE_BITS = 24);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_in;
  logic signed [SAMPLE_BITS-1:0] right_in;

  modport source (output valid, left_in, right_in, input ready);
  modport sink   (input valid, left_in, right_in, output ready);
endinterface

// File: rtl/core/sfdl_out_if.sv
// Output stream interface: one mixed stereo pair per beat.
// Standalone, parameterised on sample width.
`timescale 1ns / 1ps

interface sfdl_out_if #(parameter int SAMPLE_BITS = 24);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;

  modport source (output valid, left_out, right_out, input ready);
  modport sink   (input valid, left_out, right_out, output ready);
endinterface

// File: rtl/core/stereo_feedback_delay_line_core.sv
// Stereo feedback delay line core: sequencer, smoothing and write/read indexing.
// Depends on sfdl_pkg, sfdl_in_if, sfdl_out_if, sfdl_mod and sfdl_chan.
//
//  port      dir  kind          payload
//  samples   in   valid/ready   left_in, right_in   (SAMPLE_BITS, signed)
//  mixed     out  valid/ready   left_out, right_out (SAMPLE_BITS, signed)
//  cfg_*     in   write enable  cfg_index, cfg_data (18 bits)
//
// The core holds one item at a time; its sequence of states, set by the
// bit-serial remainder of the delay and the single port of each ring store, runs
// to its end before the next beat is accepted.
// After reset both stores are cleared, one entry a cycle, all STORE_DEPTH entries,
// before the first beat is taken. A result waits in the output register while
// the smoothing finishes; the next beat is taken once that is done.
`timescale 1ns / 1ps

module stereo_feedback_delay_line_core import sfdl_pkg::*; #(
  parameter int STORE_DEPTH = 131072,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  sfdl_in_if.sink                samples,
  sfdl_out_if.source             mixed,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW   = $clog2(STORE_DEPTH);
  localparam int LW   = AW + 1;
  localparam int DW   = AW + 31;
  localparam int PW   = AW + 32;
  localparam int CMPW = (LW > 18) ? LW : 18;

  typedef enum logic [4:0] {
    ST_CLR, ST_IDLE, ST_RD_OLD, ST_OLD, ST_WR, ST_DIV, ST_POS, ST_IDX,
    ST_RD1, ST_RD2, ST_M1, ST_M2, ST_WET, ST_MX1, ST_MX2, ST_OUT, ST_EMIT,
    ST_SM_T, ST_SM_D, ST_SM_P, ST_SM_U
  } state_t;

  state_t state;

  // configuration registers
  logic [17:0] active_length;
  logic [15:0] delay_fraction;
  logic [16:0] wet_level;
  logic [15:0] feedback_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_length  <= ACTIVE_LEN_RESET;
      delay_fraction <= '0;
      wet_level      <= '0;
      feedback_gain  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_ACTIVE_LENGTH:  active_length  <= cfg_data;
        CFG_DELAY_FRACTION: delay_fraction <= cfg_data[15:0];
        CFG_WET_LEVEL:      wet_level      <= cfg_data[16:0];
        CFG_FEEDBACK_GAIN:  feedback_gain  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // clamped length
  logic [CMPW-1:0] al_ext;
  logic [LW-1:0]   len_c;
  assign al_ext = CMPW'(active_length);
  always_comb begin
    if (al_ext < CMPW'(2)) len_c = LW'(2);
    else if (al_ext > CMPW'(STORE_DEPTH)) len_c = LW'(STORE_DEPTH);
    else len_c = al_ext[LW-1:0];
  end

  // state and working registers
  logic [AW-1:0]         wp, w_r, i1, i2, clr_cnt;
  logic [LW-1:0]         len_r;
  logic [DW-1:0]         sd;
  logic [31:0]           sm_lv, sm_fb;
  logic signed [SAMPLE_BITS-1:0] x_l, x_r;
  logic [30:0]           fb_r, ratio;
  logic [31:0]           lvl_r;
  logic [PW-1:0]         pos_raw;
  logic [DW-1:0]         tgt_dl, d_dl, st_dl;
  logic [31:0]           tgt_lv, tgt_fb, d_lv, d_fb, st_lv, st_fb;
  logic                  up_dl, up_lv, up_fb;
  logic                  out_valid;
  logic signed [SAMPLE_BITS-1:0] out_l, out_r;
  logic signed [SAMPLE_BITS-1:0] y_l, y_r;

  logic [AW-1:0]   rem;
  logic            mod_done;
  logic [PW-1:0]   span, pos_w;
  logic [AW+16:0]  frac_p;
  logic [DW-17:0]  hi_p;
  logic [47:0]     lo_p;
  logic [50:0]     lv_p, fbp;
  logic [31:0]     fb_lim;
  logic            take_in;
  logic            out_free;

  assign span     = {len_r, 31'b0};
  assign pos_w    = (pos_raw >= span) ? pos_raw - span : pos_raw;
  assign frac_p   = delay_fraction * len_r;
  assign hi_p     = d_dl[DW-1:32] * COEF_DELAY;
  assign lo_p     = d_dl[31:0] * COEF_DELAY;
  assign lv_p     = d_lv * COEF_SLOW;
  assign fbp      = d_fb * COEF_SLOW;
  assign fb_lim   = {1'b0, FB_MAX, 15'b0};
  assign take_in  = samples.valid && (state == ST_IDLE);
  assign out_free = !out_valid || mixed.ready;

  assign samples.ready   = (state == ST_IDLE);
  assign mixed.valid     = out_valid;
  assign mixed.left_out  = out_l;
  assign mixed.right_out = out_r;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLR;
      clr_cnt   <= '0;
      wp        <= '0;
      sd        <= '0;
      sm_lv     <= '0;
      sm_fb     <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == AW'(STORE_DEPTH - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (take_in) begin
            x_l   <= samples.left_in;
            x_r   <= samples.right_in;
            len_r <= len_c;
            w_r   <= ({1'b0, wp} >= len_c) ? '0 : wp;
            fb_r  <= (sm_fb > fb_lim) ? fb_lim[30:0] : sm_fb[30:0];
            lvl_r <= (sm_lv > 32'h8000_0000) ? 32'h8000_0000 : sm_lv;
            state <= ST_RD_OLD;
          end
        end
        ST_RD_OLD: state <= ST_OLD;
        ST_OLD:    state <= ST_WR;
        ST_WR:     state <= ST_DIV;
        ST_DIV:    if (mod_done) state <= ST_POS;
        ST_POS: begin
          pos_raw <= {1'b0, w_r, 31'b0} + {len_r, 31'b0} - {1'b0, rem, sd[30:0]};
          state   <= ST_IDX;
        end
        ST_IDX: begin
          i1    <= pos_w[AW+30:31];
          ratio <= pos_w[30:0];
          state <= ST_RD1;
        end
        ST_RD1: begin
          i2    <= ({1'b0, i1} + 1'b1 >= len_r) ? '0 : i1 + 1'b1;
          state <= ST_RD2;
        end
        ST_RD2: state <= ST_M1;
        ST_M1:  state <= ST_M2;
        ST_M2:  state <= ST_WET;
        ST_WET: state <= ST_MX1;
        ST_MX1: state <= ST_MX2;
        ST_MX2: state <= ST_OUT;
        ST_OUT: state <= ST_EMIT;
        ST_EMIT: begin
          if (out_free) state <= ST_SM_T;
        end
        ST_SM_T: begin
          wp     <= ({1'b0, w_r} + 1'b1 >= len_r) ? '0 : w_r + 1'b1;
          tgt_dl <= DW'({frac_p, 15'b0});
          tgt_lv <= {((wet_level > LEVEL_MAX) ? LEVEL_MAX : wet_level), 15'b0};
          tgt_fb <= {1'b0, ((feedback_gain > FB_MAX) ? FB_MAX : feedback_gain), 15'b0};
          state  <= ST_SM_D;
        end
        ST_SM_D: begin
          up_dl <= tgt_dl >= sd;
          up_lv <= tgt_lv >= sm_lv;
          up_fb <= tgt_fb >= sm_fb;
          d_dl  <= (tgt_dl >= sd) ? tgt_dl - sd : sd - tgt_dl;
          d_lv  <= (tgt_lv >= sm_lv) ? tgt_lv - sm_lv : sm_lv - tgt_lv;
          d_fb  <= (tgt_fb >= sm_fb) ? tgt_fb - sm_fb : sm_fb - tgt_fb;
          state <= ST_SM_P;
        end
        ST_SM_P: begin
          st_dl <= DW'(hi_p) + DW'(lo_p[47:32]);
          st_lv <= 32'(lv_p[50:32]);
          st_fb <= 32'(fbp[50:32]);
          state <= ST_SM_U;
        end
        ST_SM_U: begin
          sd    <= up_dl ? sd + st_dl : sd - st_dl;
          sm_lv <= up_lv ? sm_lv + st_lv : sm_lv - st_lv;
          sm_fb <= up_fb ? sm_fb + st_fb : sm_fb - st_fb;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
      // output register: load a new result or retire the one taken
      if (state == ST_EMIT && out_free) begin
        out_valid <= 1'b1;
        out_l     <= y_l;
        out_r     <= y_r;
      end else if (mixed.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // channel control decode
  chan_ctrl_t    ctrl;
  logic [AW-1:0] addr;
  always_comb begin
    ctrl.op = OP_NONE;
    addr    = w_r;
    unique case (state)
      ST_CLR:    begin ctrl.op = OP_CLR; addr = clr_cnt; end
      ST_RD_OLD: ctrl.op = OP_RD;
      ST_OLD:    ctrl.op = OP_OLD;
      ST_WR:     ctrl.op = OP_WR;
      ST_RD1:    begin ctrl.op = OP_RD; addr = i1; end
      ST_RD2:    begin ctrl.op = OP_CAP1; addr = i2; end
      ST_M1:     ctrl.op = OP_M1;
      ST_M2:     ctrl.op = OP_M2;
      ST_WET:    ctrl.op = OP_WET;
      ST_MX1:    ctrl.op = OP_MX1;
      ST_MX2:    ctrl.op = OP_MX2;
      ST_OUT:    ctrl.op = OP_OUT;
      default:   ctrl.op = OP_NONE;
    endcase
  end

  // remainder of the delay's whole part by the length
  sfdl_mod #(.AW(AW)) u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (state == ST_RD_OLD),
    .num   (sd[DW-1:31]),
    .den   (len_r),
    .rem   (rem),
    .done  (mod_done)
  );

  sfdl_chan #(.STORE_DEPTH(STORE_DEPTH), .SAMPLE_BITS(SAMPLE_BITS)) u_left (
    .clk (clk), .ctrl (ctrl), .addr (addr), .x (x_l),
    .fb (fb_r), .ratio (ratio), .lvl (lvl_r), .y (y_l)
  );

  sfdl_chan #(.STORE_DEPTH(STORE_DEPTH), .SAMPLE_BITS(SAMPLE_BITS)) u_right (
    .clk (clk), .ctrl (ctrl), .addr (addr), .x (x_r),
    .fb (fb_r), .ratio (ratio), .lvl (lvl_r), .y (y_r)
  );

endmodule

// File: rtl/core/sfdl_mod.sv
// Restoring remainder unit, one quotient bit per cycle.
// Depends on nothing but its parameter.
`timescale 1ns / 1ps

module sfdl_mod #(
  parameter int AW = 17,
  localparam int CW = $clog2(AW + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [AW-1:0] num,
  input  logic [AW:0]   den,
  output logic [AW-1:0] rem,
  output logic          done
);

  logic [AW:0]   r;
  logic [AW-1:0] q;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [AW:0]   trial;

  // shift in the next dividend bit
  assign trial = {r[AW-1:0], q[AW-1]};
  assign rem   = r[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      r    <= '0;
      q    <= num;
      cnt  <= CW'(AW);
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy) begin
      r   <= (trial >= den) ? trial - den : trial;
      q   <= {q[AW-2:0], 1'b0};
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/sfdl_chan.sv
// One channel: ring store memory plus feedback, interpolation and mix datapath.
// Depends on sfdl_pkg; sequenced by the core through chan_ctrl_t.
`timescale 1ns / 1ps

module sfdl_chan import sfdl_pkg::*; #(
  parameter int STORE_DEPTH = 131072,
  parameter int SAMPLE_BITS = 24,
  localparam int AW = $clog2(STORE_DEPTH)
) (
  input  logic                          clk,
  input  chan_ctrl_t                    ctrl,
  input  logic [AW-1:0]                 addr,
  input  logic signed [SAMPLE_BITS-1:0] x,
  input  logic [30:0]                   fb,
  input  logic [30:0]                   ratio,
  input  logic [31:0]                   lvl,
  output logic signed [SAMPLE_BITS-1:0] y
);

  localparam int S  = SAMPLE_BITS;
  localparam int CW = S + 36;
  localparam logic signed [CW-1:0] HALF = {{(CW-31){1'b0}}, 1'b1, 30'b0};
  localparam logic signed [CW-1:0] MAXV = {{(CW-S+1){1'b0}}, {(S-1){1'b1}}};
  localparam logic signed [CW-1:0] MINV = ~MAXV;

  function automatic logic signed [CW-1:0] rnd31(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] t;
    t = v + HALF;
    return t >>> 31;
  endfunction

  function automatic logic signed [S-1:0] sat_s(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] c;
    if (v > MAXV) c = MAXV;
    else if (v < MINV) c = MINV;
    else c = v;
    return c[S-1:0];
  endfunction

  logic signed [S-1:0]  mem [STORE_DEPTH];
  logic signed [S-1:0]  rdata;
  logic                 we;
  logic signed [S-1:0]  wdata;

  logic signed [S+31:0] prod_fb;
  logic signed [S-1:0]  s1, s2;
  logic signed [S+32:0] p1;
  logic signed [S+31:0] p2;
  logic signed [S+1:0]  wet;
  logic signed [S+32:0] m1;
  logic signed [S+34:0] m2;
  logic signed [CW-1:0] wet_c;
  logic signed [S-1:0]  fb_new;
  logic [31:0]          fac_r;
  logic [31:0]          fac_l;

  assign fac_r  = 32'h8000_0000 - {1'b0, ratio};
  assign fac_l  = 32'h8000_0000 - lvl;
  assign fb_new = sat_s(CW'(x) + rnd31(CW'(prod_fb)));
  assign wet_c  = rnd31(CW'(p1) + CW'(p2));
  assign we     = (ctrl.op == OP_WR) || (ctrl.op == OP_CLR);
  assign wdata  = (ctrl.op == OP_CLR) ? '0 : fb_new;

  // ring store, read data registered
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end

  // datapath registers, at most one multiply per cycle
  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_OLD:  prod_fb <= rdata * $signed({1'b0, fb});
      OP_CAP1: s1 <= rdata;
      OP_M1: begin
        s2 <= rdata;
        p1 <= s1 * $signed({1'b0, fac_r});
      end
      OP_M2:   p2  <= s2 * $signed({1'b0, ratio});
      OP_WET:  wet <= wet_c[S+1:0];
      OP_MX1:  m1  <= x * $signed({1'b0, fac_l});
      OP_MX2:  m2  <= wet * $signed({1'b0, lvl});
      OP_OUT:  y   <= sat_s(rnd31(CW'(m1) + CW'(m2)));
      default: ;
    endcase
  end

endmodule

// File: rtl/core/sfdl_checker.sv
// Port-level checks of the delay line core, attached by bind.
// Depends on stereo_feedback_delay_line_core_defines.svh.
`timescale 1ns / 1ps
`include "stereo_feedback_delay_line_core_defines.svh"

module sfdl_checker #(
  parameter int SAMPLE_BITS = 24
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [SAMPLE_BITS-1:0] out_left,
  input logic signed [SAMPLE_BITS-1:0] out_right
);

  // a stalled result beat stays offered
  `SFDL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  // and keeps its payload
  `SFDL_ASSERT_NEXT(a_out_stable, out_valid && !out_ready,
                    $stable(out_left) && $stable(out_right))
  // one item in flight: no new beat right after one is taken
  `SFDL_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready)
  // a result appears only while its item is still being finished
  `SFDL_ASSERT_NOW(a_out_in_flight, $rose(out_valid), !in_ready)

endmodule

bind stereo_feedback_delay_line_core sfdl_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (samples.valid),
  .in_ready  (samples.ready),
  .out_valid (mixed.valid),
  .out_ready (mixed.ready),
  .out_left  (mixed.left_out),
  .out_right (mixed.right_out)
);

// File: verif/tb.sv
// Testbench for the stereo feedback delay line core: scoreboard class with a
// bit-exact predictor, stream drivers and a register write task.
// Depends on sfdl_pkg, sfdl_in_if, sfdl_out_if and stereo_feedback_delay_line_core.
`timescale 1ns / 1ps

// Predicts mixed pairs from accepted sample pairs and checks the results
class echo_scoreboard;
  localparam int DEPTH = 131072;
  localparam longint ONE = 64'h8000_0000;

  logic signed [23:0] lstore [int];
  logic signed [23:0] rstore [int];
  longint unsigned wpos, sdelay, slevel, sfb;
  longint unsigned reg_len, reg_frac, reg_lvl, reg_fb;
  logic signed [23:0] exp_l [$];
  logic signed [23:0] exp_r [$];
  int errors;

  function new();
    wpos = 0; sdelay = 0; slevel = 0; sfb = 0;
    reg_len = 96000; reg_frac = 0; reg_lvl = 0; reg_fb = 0;
    errors = 0;
  endfunction

  function void write_reg(sfdl_pkg::cfg_index_t idx, longint unsigned v);
    case (idx)
      sfdl_pkg::CFG_ACTIVE_LENGTH:  reg_len = v & 18'h3ffff;
      sfdl_pkg::CFG_DELAY_FRACTION: reg_frac = v & 16'hffff;
      sfdl_pkg::CFG_WET_LEVEL:      reg_lvl = v & 17'h1ffff;
      sfdl_pkg::CFG_FEEDBACK_GAIN:  reg_fb = v & 16'hffff;
      default: ;
    endcase
  endfunction

  // round(x / 2^31), ties upward
  function longint round31(longint x);
    longint t;
    t = x + (ONE >> 1);
    return t >>> 31;
  endfunction

  function longint clip(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function longint unsigned glide(longint unsigned cur, longint unsigned tgt,
                                  longint unsigned coef);
    longint unsigned d, stp;
    d = (tgt >= cur) ? tgt - cur : cur - tgt;
    stp = (d >> 32) * coef + (((d & 64'hffff_ffff) * coef) >> 32);
    return (tgt >= cur) ? cur + stp : cur - stp;
  endfunction

  function longint mix_chan(bit right, longint x, int w, longint unsigned fbk,
                            longint unsigned lvl, int i1, int i2,
                            longint unsigned ratio);
    longint old, s1, s2, wet, m;
    old = right ? (rstore.exists(w) ? rstore[w] : 0) : (lstore.exists(w) ? lstore[w] : 0);
    if (right) rstore[w] = 24'(clip(x + round31(old * longint'(fbk))));
    else lstore[w] = 24'(clip(x + round31(old * longint'(fbk))));
    if (right) begin
      s1 = rstore.exists(i1) ? rstore[i1] : 0;
      s2 = rstore.exists(i2) ? rstore[i2] : 0;
    end else begin
      s1 = lstore.exists(i1) ? lstore[i1] : 0;
      s2 = lstore.exists(i2) ? lstore[i2] : 0;
    end
    wet = round31(s1 * longint'(ONE - ratio) + s2 * longint'(ratio));
    m = x * longint'(ONE - lvl) + wet * longint'(lvl);
    return clip(round31(m));
  endfunction

  // Note one accepted sample pair
  function void note_input(logic signed [23:0] l, logic signed [23:0] r);
    longint unsigned len, span, dmod, pos, ratio, fbk, lvl, tl, tf;
    int i1, i2, w;
    len = reg_len < 2 ? 2 : (reg_len > DEPTH ? DEPTH : reg_len);
    span = len << 31;
    if (wpos >= len) wpos = 0;
    w = int'(wpos);
    fbk = sfb > (64'd62259 << 15) ? (64'd62259 << 15) : sfb;
    lvl = slevel > ONE ? ONE : slevel;
    dmod = sdelay % span;
    pos = (longint'(w) << 31) + span - dmod;
    if (pos >= span) pos -= span;
    i1 = int'(pos >> 31);
    ratio = pos & (ONE - 1);
    i2 = i1 + 1;
    if (i2 >= len) i2 = 0;
    exp_l.push_back(24'(mix_chan(0, l, w, fbk, lvl, i1, i2, ratio)));
    exp_r.push_back(24'(mix_chan(1, r, w, fbk, lvl, i1, i2, ratio)));
    wpos = w + 1;
    if (wpos >= len) wpos = 0;
    tl = reg_lvl > 65536 ? 65536 : reg_lvl;
    tf = reg_fb > 62259 ? 62259 : reg_fb;
    sdelay = glide(sdelay, (reg_frac * len) << 15, 42950);
    slevel = glide(slevel, tl << 15, 429497);
    sfb = glide(sfb, tf << 15, 429497);
  endfunction

  // Check one result beat against the oldest expectation
  function void check_result(logic signed [23:0] l, logic signed [23:0] r);
    logic signed [23:0] el, er;
    if (exp_l.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result %0d %0d", l, r);
      return;
    end
    el = exp_l.pop_front();
    er = exp_r.pop_front();
    if (el !== l || er !== r) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: exp %0d %0d got %0d %0d", el, er, l, r);
    end
  endfunction
endclass

module tb;
  import sfdl_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  bit quiet = 0;
  longint cycles = 0;
  localparam longint LIMIT = 3000000;

  sfdl_in_if  #(24) samples();
  sfdl_out_if #(24) mixed();

  stereo_feedback_delay_line_core u_top (
    .clk(clk), .rst(rst), .samples(samples), .mixed(mixed),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  echo_scoreboard sb = new();

  always #5 clk = ~clk;

  initial begin
    samples.valid = 0;
    samples.left_in = '0;
    samples.right_in = '0;
    mixed.ready = 0;
  end

  // Output side: sample at rising edge, change ready at falling edge
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && mixed.valid && mixed.ready)
      sb.check_result(mixed.left_out, mixed.right_out);
    if (cycles > LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    int gap;
    @(negedge clk);
    forever begin
      mixed.ready = 1;
      gap = quiet ? 0 : (($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0);
      repeat ($urandom_range(1, 8)) @(negedge clk);
      if (gap > 0) begin
        mixed.ready = 0;
        repeat (gap) @(negedge clk);
      end
    end
  end

  task automatic cfg_write(cfg_index_t idx, logic [17:0] v);
    cfg_we = 1; cfg_index = idx; cfg_data = v;
    @(negedge clk);
    cfg_we = 0;
    sb.write_reg(idx, v);
  endtask

  // Offer one pair and hold it until accepted
  task automatic send_pair(logic signed [23:0] l, logic signed [23:0] r);
    if (!quiet && $urandom_range(0, 4) == 0) repeat ($urandom_range(1, 6)) @(negedge clk);
    samples.valid = 1; samples.left_in = l; samples.right_in = r;
    @(posedge clk);
    while (!samples.ready) @(posedge clk);
    sb.note_input(l, r);
    @(negedge clk);
    samples.valid = 0;
  endtask

  task automatic drain();
    while (sb.exp_l.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  function automatic logic signed [23:0] rnd_sample();
    case ($urandom_range(0, 5))
      0: return 24'sh7fffff;
      1: return 24'sh800000;
      default: return 24'($urandom());
    endcase
  endfunction

  initial begin
    int n;
    logic [17:0] lens [6] = '{2, 3, 5, 17, 64, 131072};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: extremes with short and out-of-range lengths
    cfg_write(CFG_ACTIVE_LENGTH, 0);
    cfg_write(CFG_DELAY_FRACTION, 16'hffff);
    cfg_write(CFG_WET_LEVEL, 17'h1ffff);
    cfg_write(CFG_FEEDBACK_GAIN, 16'hffff);
    send_pair(24'sh7fffff, 24'sh800000);
    send_pair(24'sh800000, 24'sh7fffff);
    send_pair(0, 0);
    send_pair(24'sh7fffff, 24'sh7fffff);
    send_pair(-1, 1);
    send_pair(24'sh555555, 24'shaaaaaa);
    drain();
    cfg_write(CFG_ACTIVE_LENGTH, 18'h3ffff);
    cfg_write(CFG_WET_LEVEL, 65536);
    cfg_write(CFG_FEEDBACK_GAIN, 62259);
    for (int i = 0; i < 8; i++) send_pair(rnd_sample(), rnd_sample());
    drain();
    cfg_write(CFG_ACTIVE_LENGTH, 4);
    cfg_write(CFG_DELAY_FRACTION, 0);
    cfg_write(CFG_WET_LEVEL, 0);
    cfg_write(CFG_FEEDBACK_GAIN, 0);
    for (int i = 0; i < 6; i++) send_pair(rnd_sample(), rnd_sample());
    drain();

    // Random phases over several settings
    for (int ph = 0; ph < 12; ph++) begin
      cfg_write(CFG_ACTIVE_LENGTH, 18'(lens[$urandom_range(0, 4)] +
                ($urandom_range(0, 3) == 0 ? $urandom_range(0, 40) : 0)));
      cfg_write(CFG_DELAY_FRACTION, 18'($urandom_range(0, 65535)));
      cfg_write(CFG_WET_LEVEL,
                18'($urandom_range(0, 3) == 0 ? 65536 : $urandom_range(0, 131071)));
      cfg_write(CFG_FEEDBACK_GAIN,
                18'($urandom_range(0, 3) == 0 ? 62259 : $urandom_range(0, 65535)));
      if (ph >= 10) quiet = 1;
      n = 36;
      for (int i = 0; i < n; i++) begin
        send_pair(rnd_sample(), rnd_sample());
        if (ph == 3 && i == 10)
          while (sb.exp_l.size() != 0) @(negedge clk);
      end
      drain();
    end

    if (sb.errors == 0 && sb.exp_l.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule
